### src/lda_pkg.sv
// Shared constants, control word type and microcode table for the landing detector.
`timescale 1ns / 1ps
package lda_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int MAG_W = 16;
   localparam int TIME_W = 32;
   localparam int AXIS_W = 16;
   localparam int BAND_W = 16;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W = CNT_W + 1;
   localparam int SUM_W = MAG_W + CNT_W;
   localparam int ITER_W = $clog2(SUM_W);
   localparam int SQ_W = 32;
   localparam int REQ_W = 80;
   localparam int RSP_W = 40;
   localparam int RSP_PAD_W = RSP_W - (2 * MAG_W + 3);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(2);
   localparam logic [SLOT_W-1:0] DEPTH_SLOT = SLOT_W'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(MAG_W - 1);
   localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(SUM_W - 1);
   localparam logic [SQ_W-1:0] ROOT_TOP = SQ_W'(32'h4000_0000);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SPAN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 2'd2;

   localparam logic [TIME_W-1:0] SPAN_RESET = 32'd5000;
   localparam logic [BAND_W-1:0] BAND_LOW_RESET = 16'd900;
   localparam logic [BAND_W-1:0] BAND_HIGH_RESET = 16'd1100;

   localparam int PC_W = 4;
   localparam int OP_W = 4;
   localparam int CND_W = 4;

   localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
   localparam logic [OP_W-1:0] OP_SQX = 4'd1;
   localparam logic [OP_W-1:0] OP_SQY = 4'd2;
   localparam logic [OP_W-1:0] OP_SQZ = 4'd3;
   localparam logic [OP_W-1:0] OP_ROOT = 4'd4;
   localparam logic [OP_W-1:0] OP_READ = 4'd5;
   localparam logic [OP_W-1:0] OP_DROP = 4'd6;
   localparam logic [OP_W-1:0] OP_WRITE = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL_LO = 4'd8;
   localparam logic [OP_W-1:0] OP_MUL_HI = 4'd9;
   localparam logic [OP_W-1:0] OP_LAND = 4'd10;
   localparam logic [OP_W-1:0] OP_DIV = 4'd11;
   localparam logic [OP_W-1:0] OP_DONE = 4'd12;
   localparam logic [OP_W-1:0] OP_OUT = 4'd13;
   localparam logic [OP_W-1:0] OP_NOP = 4'd14;

   localparam logic [CND_W-1:0] CND_NONE = 4'd0;
   localparam logic [CND_W-1:0] CND_ALWAYS = 4'd1;
   localparam logic [CND_W-1:0] CND_NO_REQ = 4'd2;
   localparam logic [CND_W-1:0] CND_ROOT_MORE = 4'd3;
   localparam logic [CND_W-1:0] CND_DIV_MORE = 4'd4;
   localparam logic [CND_W-1:0] CND_NOT_FULL = 4'd5;
   localparam logic [CND_W-1:0] CND_FEW = 4'd6;
   localparam logic [CND_W-1:0] CND_NO_SPAN = 4'd7;
   localparam logic [CND_W-1:0] CND_OUT_BUSY = 4'd8;

   localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
   localparam logic [PC_W-1:0] ST_SQX = 4'd1;
   localparam logic [PC_W-1:0] ST_SQY = 4'd2;
   localparam logic [PC_W-1:0] ST_SQZ = 4'd3;
   localparam logic [PC_W-1:0] ST_ROOT = 4'd4;
   localparam logic [PC_W-1:0] ST_FULL = 4'd5;
   localparam logic [PC_W-1:0] ST_SAT = 4'd6;
   localparam logic [PC_W-1:0] ST_WRITE = 4'd7;
   localparam logic [PC_W-1:0] ST_OLDEST = 4'd8;
   localparam logic [PC_W-1:0] ST_SPAN = 4'd9;
   localparam logic [PC_W-1:0] ST_BAND = 4'd10;
   localparam logic [PC_W-1:0] ST_LAND = 4'd11;
   localparam logic [PC_W-1:0] ST_DIV = 4'd12;
   localparam logic [PC_W-1:0] ST_DONE = 4'd13;
   localparam logic [PC_W-1:0] ST_OUT = 4'd14;
   localparam logic [PC_W-1:0] ST_BACK = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [CND_W-1:0] cond;
      logic [PC_W-1:0] target;
   } ctl_word_type;

   function automatic ctl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      case (pc)
         ST_IDLE: w = '{op: OP_IDLE, cond: CND_NO_REQ, target: ST_IDLE};
         ST_SQX: w = '{op: OP_SQX, cond: CND_NONE, target: ST_IDLE};
         ST_SQY: w = '{op: OP_SQY, cond: CND_NONE, target: ST_IDLE};
         ST_SQZ: w = '{op: OP_SQZ, cond: CND_NONE, target: ST_IDLE};
         ST_ROOT: w = '{op: OP_ROOT, cond: CND_ROOT_MORE, target: ST_ROOT};
         ST_FULL: w = '{op: OP_READ, cond: CND_NOT_FULL, target: ST_WRITE};
         ST_SAT: w = '{op: OP_DROP, cond: CND_NONE, target: ST_IDLE};
         ST_WRITE: w = '{op: OP_WRITE, cond: CND_NONE, target: ST_IDLE};
         ST_OLDEST: w = '{op: OP_READ, cond: CND_FEW, target: ST_OUT};
         ST_SPAN: w = '{op: OP_MUL_LO, cond: CND_NO_SPAN, target: ST_OUT};
         ST_BAND: w = '{op: OP_MUL_HI, cond: CND_NONE, target: ST_IDLE};
         ST_LAND: w = '{op: OP_LAND, cond: CND_NONE, target: ST_IDLE};
         ST_DIV: w = '{op: OP_DIV, cond: CND_DIV_MORE, target: ST_DIV};
         ST_DONE: w = '{op: OP_DONE, cond: CND_NONE, target: ST_IDLE};
         ST_OUT: w = '{op: OP_OUT, cond: CND_OUT_BUSY, target: ST_OUT};
         ST_BACK: w = '{op: OP_NOP, cond: CND_ALWAYS, target: ST_IDLE};
         default: w = '{op: OP_NOP, cond: CND_ALWAYS, target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

### src/lda_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lda_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/landing_detector_windowed_accel_top.sv
// Landing detector: microcoded sequencer over a shared root, divide and ring datapath.
// Requests are taken only in the idle state, so one request is processed at a time; the
// 16-step root loop runs for every request, the SUM_W-step divide loop only when an
// average is computed. A waiting result stalls the next request in the output state until it is taken.
// Reset: synchronous, active high; clears ring pointers, sum, landed flag, registers to defaults.
`timescale 1ns / 1ps
module landing_detector_windowed_accel_top
   import lda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x, accel_y, accel_z, sample_time
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // magnitude, window_average, average_ready, landed, parachute_drive, zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctl_word_type ctl;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic landed_ff, landed_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] span_ff;
   logic [BAND_W-1:0] band_low_ff, band_high_ff;

   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_W-1:0] time_ff;
   logic [SQ_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SUM_W-1:0] prod_ff, prod_in;
   logic above_ff, above_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic ready_ff, ready_in;
   logic [MAG_W-1:0] avg_ff, avg_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic out_free;
   logic jump;
   logic signed [AXIS_W-1:0] sq_sel;
   logic signed [SQ_W-1:0] sq_prod;
   logic [SQ_W-1:0] root_bit;
   logic [SQ_W:0] root_trial;
   logic [CNT_W:0] div_shift;
   logic [BAND_W-1:0] band_sel;
   logic [SLOT_W-1:0] slot_sum;
   logic [PTR_W-1:0] slot;
   logic [TIME_W-1:0] span_now;
   logic [PTR_W-1:0] head_next;
   logic [MAG_W-1:0] mag_rdata;
   logic [TIME_W-1:0] time_rdata;
   logic mem_wr;
   logic mem_rd;

   assign ctl = ucode_rom(pc_ff);
   assign req_tready = (ctl.op == OP_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign sq_sel = (ctl.op == OP_SQX) ? ax_ff : ((ctl.op == OP_SQY) ? ay_ff : az_ff);
   assign sq_prod = sq_sel * sq_sel;
   assign root_bit = ROOT_TOP >> {iter_ff, 1'b0};
   assign root_trial = {1'b0, root_ff} + {1'b0, root_bit};
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign band_sel = (ctl.op == OP_MUL_LO) ? band_low_ff : band_high_ff;
   assign slot_sum = SLOT_W'(head_ff) + SLOT_W'(count_ff);
   assign slot = (slot_sum >= DEPTH_SLOT) ? PTR_W'(slot_sum - DEPTH_SLOT) : PTR_W'(slot_sum);
   assign span_now = time_ff - time_rdata;
   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign mem_wr = (ctl.op == OP_WRITE);
   assign mem_rd = (ctl.op == OP_READ);

   always_comb begin
      case (ctl.cond)
         CND_NONE: jump = 1'b0;
         CND_ALWAYS: jump = 1'b1;
         CND_NO_REQ: jump = !req_tvalid;
         CND_ROOT_MORE: jump = (iter_ff != ROOT_LAST);
         CND_DIV_MORE: jump = (iter_ff != DIV_LAST);
         CND_NOT_FULL: jump = (count_ff != DEPTH_CNT);
         CND_FEW: jump = (count_ff < MIN_COUNT);
         CND_NO_SPAN: jump = (span_now <= span_ff);
         CND_OUT_BUSY: jump = !out_free;
         default: jump = 1'b1;
      endcase
      pc_in = jump ? ctl.target : pc_ff + 1'b1;
   end

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      landed_in = landed_ff;
      iter_in = iter_ff;
      acc_in = acc_ff;
      root_in = root_ff;
      prod_in = prod_ff;
      above_in = above_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      ready_in = ready_ff;
      avg_in = avg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (ctl.op)
         OP_IDLE: begin
            ready_in = 1'b0;
            avg_in = '0;
         end
         OP_SQX: acc_in = SQ_W'(sq_prod);
         OP_SQY: acc_in = acc_ff + SQ_W'(sq_prod);
         OP_SQZ: begin
            acc_in = acc_ff + SQ_W'(sq_prod);
            iter_in = '0;
            root_in = '0;
         end
         OP_ROOT: begin
            iter_in = iter_ff + 1'b1;
            if ({1'b0, acc_ff} >= root_trial) begin
               acc_in = acc_ff - root_trial[SQ_W-1:0];
               root_in = (root_ff >> 1) + root_bit;
            end else begin
               root_in = root_ff >> 1;
            end
         end
         OP_DROP: begin
            sum_in = sum_ff - SUM_W'(mag_rdata);
            head_in = head_next;
            count_in = count_ff - 1'b1;
         end
         OP_WRITE: begin
            sum_in = sum_ff + SUM_W'(root_ff[MAG_W-1:0]);
            count_in = count_ff + 1'b1;
         end
         OP_MUL_LO, OP_MUL_HI: begin
            prod_in = SUM_W'(band_sel) * SUM_W'(count_ff);
            above_in = (sum_ff > prod_ff);
         end
         OP_LAND: begin
            if (above_ff && (sum_ff < prod_ff)) begin
               landed_in = 1'b1;
            end
            iter_in = '0;
            rem_in = '0;
            quo_in = sum_ff;
         end
         OP_DIV: begin
            iter_in = iter_ff + 1'b1;
            if (div_shift >= {1'b0, count_ff}) begin
               rem_in = CNT_W'(div_shift - {1'b0, count_ff});
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_shift[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
         end
         OP_DONE: begin
            sum_in = sum_ff - SUM_W'(mag_rdata);
            head_in = head_next;
            count_in = count_ff - 1'b1;
            ready_in = 1'b1;
            avg_in = quo_ff[MAG_W-1:0];
         end
         OP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {RSP_PAD_W'(0), !landed_ff, landed_ff, ready_ff, avg_ff,
                              root_ff[MAG_W-1:0]};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         landed_ff <= 1'b0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
         span_ff <= SPAN_RESET;
         band_low_ff <= BAND_LOW_RESET;
         band_high_ff <= BAND_HIGH_RESET;
      end else begin
         pc_ff <= pc_in;
         head_ff <= head_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         landed_ff <= landed_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SPAN: span_ff <= csr_data;
               CSR_BAND_LOW: band_low_ff <= csr_data[BAND_W-1:0];
               CSR_BAND_HIGH: band_high_ff <= csr_data[BAND_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         time_ff <= req_tdata[79:48];
      end
      acc_ff <= acc_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      above_ff <= above_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      ready_ff <= ready_in;
      avg_ff <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   lda_ram #(
      .WIDTH(MAG_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_mag_ram (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(slot),
      .wr_data(root_ff[MAG_W-1:0]),
      .rd_en  (mem_rd),
      .rd_addr(head_ff),
      .rd_data(mag_rdata)
   );

   lda_ram #(
      .WIDTH(TIME_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_time_ram (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(slot),
      .wr_data(time_ff),
      .rd_en  (mem_rd),
      .rd_addr(head_ff),
      .rd_data(time_rdata)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("ring count above window depth");
   assert property (@(posedge clock) disable iff (reset) landed_ff |=> landed_ff)
      else $error("landed flag cleared");
   assert property (@(posedge clock) disable iff (reset) (count_ff == '0) |-> (sum_ff == '0))
      else $error("running sum nonzero with empty window");
`endif

endmodule

### test/tb.sv
// Testbench for the landing detector: checks each result field against a window model.
`timescale 1ns / 1ps
module tb
   import lda_pkg::*;
();

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [TIME_W-1:0]        sample_time;
      logic signed [AXIS_W-1:0] accel_z;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_x;
   } accel_sample_type;

   typedef struct packed {
      logic             parachute_drive;
      logic             landed;
      logic             average_ready;
      logic [MAG_W-1:0] window_average;
      logic [MAG_W-1:0] magnitude;
   } landing_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   landing_detector_windowed_accel_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // window model state
   logic [MAG_W-1:0]  mag_hist [WINDOW_DEPTH];
   logic [TIME_W-1:0] stamp_hist [WINDOW_DEPTH];
   int unsigned       win_head = 0;
   int unsigned       win_count = 0;
   longint unsigned   win_sum = 0;
   logic              touched_down = 1'b0;

   logic [TIME_W-1:0] cfg_span = SPAN_RESET;
   logic [BAND_W-1:0] cfg_band_low = BAND_LOW_RESET;
   logic [BAND_W-1:0] cfg_band_high = BAND_HIGH_RESET;

   landing_report_type due_reports [$];
   logic [TIME_W-1:0] stamp_now = '0;
   bit                idle_on = 1'b1;
   int unsigned       req_gap = 0;
   bit                req_held = 1'b0;
   int                mismatch_count = 0;
   int                samples_sent = 0;
   int                reports_checked = 0;
   int                csr_writes = 0;
   int                landed_at = -1;
   int                cycle_count = 0;

   function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem = n;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return MAG_W'(root);
   endfunction

   function automatic void retire_oldest();
      if (win_count == 0) return;
      win_sum -= mag_hist[win_head];
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_count--;
   endfunction

   function automatic landing_report_type predict_landing(input accel_sample_type s);
      landing_report_type r;
      longint signed xs, ys, zs;
      longint unsigned sq;
      int unsigned slot;
      logic [TIME_W-1:0] span;
      xs = s.accel_x;
      ys = s.accel_y;
      zs = s.accel_z;
      sq = longint'(xs * xs) + longint'(ys * ys) + longint'(zs * zs);
      r = '0;
      r.magnitude = floor_root(sq);
      if (win_count >= WINDOW_DEPTH) retire_oldest();
      slot = (win_head + win_count) % WINDOW_DEPTH;
      mag_hist[slot] = r.magnitude;
      stamp_hist[slot] = s.sample_time;
      win_count++;
      win_sum += r.magnitude;
      if (win_count >= 2) begin
         span = s.sample_time - stamp_hist[win_head];
         if (span > cfg_span) begin
            r.average_ready = 1'b1;
            r.window_average = MAG_W'(win_sum / win_count);
            if (win_sum > longint'(cfg_band_low) * win_count &&
                win_sum < longint'(cfg_band_high) * win_count) begin
               if (!touched_down) landed_at = samples_sent;
               touched_down = 1'b1;
            end
            retire_oldest();
         end
      end
      r.landed = touched_down;
      r.parachute_drive = ~touched_down;
      return r;
   endfunction

   // aim 0 draws all axes over full range, else z is near that magnitude, x and y small
   function automatic accel_sample_type draw_sample(input int unsigned mag_aim,
                                                    input int unsigned step_max);
      accel_sample_type s;
      int zv;
      if (mag_aim == 0) begin
         s.accel_x = AXIS_W'($urandom);
         s.accel_y = AXIS_W'($urandom);
         s.accel_z = AXIS_W'($urandom);
      end else begin
         zv = int'(mag_aim) + int'($urandom_range(0, 8)) - 4;
         if ($urandom_range(0, 1) == 1) zv = -zv;
         s.accel_x = AXIS_W'(int'($urandom_range(0, 6)) - 3);
         s.accel_y = AXIS_W'(int'($urandom_range(0, 6)) - 3);
         s.accel_z = AXIS_W'(zv);
      end
      if ($urandom_range(0, 15) == 0) stamp_now = $urandom;
      else stamp_now = stamp_now + $urandom_range(0, step_max);
      s.sample_time = stamp_now;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic send_sample(input accel_sample_type s);
      landing_report_type expected;
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_tdata <= s;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      samples_sent++;
      expected = predict_landing(s);
      due_reports.insert(due_reports.size(), expected);
      req_gap = idle_on ? $urandom_range(0, 5) : 0;
      req_held = (req_gap == 0);
      if (!req_held) req_tvalid <= 1'b0;
   endtask

   task automatic send_axes(input int x, input int y, input int z, input logic [31:0] t);
      accel_sample_type s;
      s.accel_x = AXIS_W'(x);
      s.accel_y = AXIS_W'(y);
      s.accel_z = AXIS_W'(z);
      s.sample_time = t;
      stamp_now = t;
      send_sample(s);
   endtask

   task automatic drain_results();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      while (due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_window(input logic [31:0] span, input logic [15:0] lo,
                                 input logic [15:0] hi);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [CSR_DATA_W-1:0] val [3];
      idx = '{CSR_WINDOW_SPAN, CSR_BAND_LOW, CSR_BAND_HIGH};
      val = '{span, 32'(lo), 32'(hi)};
      drain_results();
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_data <= val[i];
         csr_valid <= 1'b1;
         do @(negedge clock); while (!csr_ready);
         @(posedge clock);
         csr_writes++;
      end
      csr_valid <= 1'b0;
      cfg_span = span;
      cfg_band_low = lo;
      cfg_band_high = hi;
   endtask

   task automatic test_reset_defaults();
      send_axes(0, 0, 0, 32'd0);
      send_axes(32767, 32767, 32767, 32'd5000);
      send_axes(-32768, -32768, -32768, 32'd5001);
      send_axes(-32768, 0, 0, 32'hFFFF_FF00);
      send_axes(0, -32768, 0, 32'h0000_1000);
      send_axes(0, 0, 32767, 32'h0000_1000);
      send_axes(1, -1, 1, 32'h8000_0000);
      send_axes(-1, 0, 0, 32'hFFFF_FFFF);
   endtask

   task automatic test_band_edges();
      program_window(32'd0, 16'd999, 16'd1000);
      for (int i = 0; i < 4; i++) send_axes(0, 0, 1000, stamp_now + 1);
      program_window(32'd0, 16'd1000, 16'd1001);
      for (int i = 0; i < 4; i++) send_axes(0, 1000, 0, stamp_now + 1);
   endtask

   task automatic test_empty_band();
      program_window(32'd0, 16'hFFFF, 16'h0000);
      send_axes(300, -400, 0, stamp_now);
      send_axes(-300, 400, 0, stamp_now);
      send_axes(0, 0, -500, stamp_now);
      send_axes(0, 0, 500, stamp_now + 1);
   endtask

   task automatic test_full_window();
      program_window(32'hFFFF_FFFF, 16'd0, 16'd0);
      for (int i = 0; i < 80; i++) send_sample(draw_sample(0, 40));
      program_window(32'd100, 16'd0, 16'd0);
      for (int i = 0; i < 10; i++) send_sample(draw_sample(0, 40));
   endtask

   task automatic test_random_windows();
      logic [31:0] span;
      logic [15:0] lo, hi;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin span = 32'd0; lo = 16'hFFFF; hi = 16'h0000; end
            1: begin span = 32'hFFFF_FFFF; lo = 16'h0000; hi = 16'h0000; end
            2: span = $urandom_range(0, 200);
            3: span = $urandom_range(0, 3000);
            4: span = $urandom;
            default: span = $urandom_range(0, 1000);
         endcase
         if (p >= 2) begin
            lo = 16'($urandom_range(0, 65535));
            hi = 16'($urandom_range(0, lo));
         end
         program_window(span, lo, hi);
         idle_on = (p != 3);
         for (int i = 0; i < 90; i++)
            send_sample(draw_sample(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32000),
                                    span / 4 + 20));
      end
      idle_on = 1'b1;
   endtask

   task automatic test_landing_sequence();
      program_window(32'd50, BAND_LOW_RESET, BAND_HIGH_RESET);
      for (int i = 0; i < 40; i++) send_sample(draw_sample(1000, 30));
      program_window(32'd0, 16'd0, 16'hFFFF);
      for (int i = 0; i < 60; i++) send_sample(draw_sample($urandom_range(0, 32000), 20));
      program_window($urandom_range(0, 2000), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
      idle_on = 1'b0;
      for (int i = 0; i < 60; i++) send_sample(draw_sample($urandom_range(0, 32000), 600));
      idle_on = 1'b1;
      program_window($urandom, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      for (int i = 0; i < 60; i++) send_sample(draw_sample(0, 32'hFFFF_FFFF));
   endtask

   initial begin : rsp_sink
      int stall;
      landing_report_type got, want;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         got = rsp_tdata[2 * MAG_W + 2:0];
         @(posedge clock);
         if (due_reports.size() == 0) begin
            report_mismatch($sformatf("result %h with no pending request", got));
         end else begin
            want = due_reports.pop_front();
            reports_checked++;
            if (got.magnitude !== want.magnitude)
               report_mismatch($sformatf("magnitude %0d, want %0d", got.magnitude,
                                         want.magnitude));
            if (got.window_average !== want.window_average)
               report_mismatch($sformatf("window_average %0d, want %0d", got.window_average,
                                         want.window_average));
            if (got.average_ready !== want.average_ready)
               report_mismatch($sformatf("average_ready %b, want %b", got.average_ready,
                                         want.average_ready));
            if (got.landed !== want.landed)
               report_mismatch($sformatf("landed %b, want %b", got.landed, want.landed));
            if (got.parachute_drive !== want.parachute_drive)
               report_mismatch($sformatf("parachute_drive %b, want %b", got.parachute_drive,
                                         want.parachute_drive));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_reports.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : main
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_band_edges();
      test_empty_band();
      test_full_window();
      test_random_windows();
      test_landing_sequence();
      drain_results();
      repeat (60) @(posedge clock);
      $display("sent %0d samples, checked %0d results, %0d register writes", samples_sent,
               reports_checked, csr_writes);
      $display("touchdown first predicted at sample %0d, saturation and wrapped stamps included",
               landed_at);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
